// File: rtl/core/stripe_write_splitter_unit_macros.svh
// Assertion macros shared by the stripe write splitter RTL.
`ifndef STRIPE_WRITE_SPLITTER_UNIT_MACROS_SVH
`define STRIPE_WRITE_SPLITTER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication, off while reset is asserted
`define SWS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sws assertion failed");

// next-cycle implication, off while reset is asserted
`define SWS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sws assertion failed");

`else

`define SWS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SWS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/core/sws_pkg.sv
// Types and constants of the stripe write splitter.
package sws_pkg;

    // limits
    localparam int unsigned MAX_CHUNKS  = 64;
    localparam int unsigned MAX_STRIPES = 16;
    localparam int unsigned LANES_MAX   = 16;
    localparam int unsigned PARTS_MAX   = (MAX_STRIPES < LANES_MAX) ? MAX_STRIPES : LANES_MAX;

    // field widths
    localparam int unsigned OFF_W  = 40;
    localparam int unsigned LEN_W  = 24;
    localparam int unsigned UNIT_W = 21;
    localparam int unsigned CNT_W  = 5;
    localparam int unsigned PART_W = 4;
    localparam int unsigned ROW_W  = 25;   // stripe_count * stripe_unit <= 2^24

    localparam logic [UNIT_W-1:0] UNIT_MAX  = 21'd1048576;
    localparam logic [CNT_W-1:0]  SCNT_MAX  = CNT_W'(PARTS_MAX);
    localparam logic [CNT_W-1:0]  WCNT_MAX  = CNT_W'(LANES_MAX);

    // reset values
    localparam logic [CNT_W-1:0]  RST_STRIPE_COUNT = CNT_W'((4 < PARTS_MAX) ? 4 : PARTS_MAX);
    localparam logic [UNIT_W-1:0] RST_STRIPE_UNIT  = 21'd131072;
    localparam logic [CNT_W-1:0]  RST_WRITER_COUNT = 5'd4;

    // register map, word index = paddr[3:2]
    typedef enum logic [1:0] {
        REG_STRIPE_COUNT = 2'd0,
        REG_STRIPE_UNIT  = 2'd1,
        REG_WRITER_COUNT = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [CNT_W-1:0]  stripe_count;
        logic [UNIT_W-1:0] stripe_unit;
        logic [CNT_W-1:0]  writer_count;
    } t_cfg;

    // one classified write, handed from front to back
    typedef struct packed {
        logic [OFF_W-1:0]  pbase;     // row index * stripe_unit
        logic [PART_W-1:0] part;      // part of the first chunk
        logic [UNIT_W-1:0] unit_off;  // offset inside the first unit
        logic [LEN_W-1:0]  len;
        logic              too_long;
    } t_desc;

    typedef struct packed {
        logic [PART_W-1:0] part_index;
        logic [OFF_W-1:0]  part_offset;
        logic [UNIT_W-1:0] chunk_length;
        logic [LEN_W-1:0]  source_offset;
        logic [PART_W-1:0] writer_index;
        logic              last;
        logic              too_long;
    } t_chunk;

    typedef enum logic [2:0] {
        F_IDLE,
        F_DIV,
        F_PART,
        F_MUL,
        F_PUSH
    } t_front_state;

endpackage

// File: rtl/core/sws_front.sv
// Front end: takes a write, finds row, part and unit offset, queues a descriptor.
module sws_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  sws_pkg::t_cfg              i_cfg,
    input  logic                       i_start,
    input  logic [sws_pkg::OFF_W-1:0]  i_write_offset,
    input  logic [sws_pkg::LEN_W-1:0]  i_write_length,
    output logic                       o_busy,
    input  logic                       i_full,
    output logic                       o_push,
    output sws_pkg::t_desc             o_desc
);
    import sws_pkg::*;

    localparam logic [26:0] SPAN = 27'(MAX_CHUNKS - 1);

    t_front_state        r_state, n_state;
    logic [5:0]          r_cnt, n_cnt;
    logic [ROW_W-1:0]    r_row, n_row;
    logic [OFF_W-1:0]    r_quo, n_quo;
    logic [ROW_W-1:0]    r_rem, n_rem;
    logic [LEN_W-1:0]    r_len, n_len;
    logic [PART_W-1:0]   r_part, n_part;
    logic [OFF_W-1:0]    r_acc, n_acc;
    logic [OFF_W-1:0]    r_mcand, n_mcand;
    logic [UNIT_W-1:0]   r_mplier, n_mplier;

    logic [25:0]         row_prod;
    logic [ROW_W:0]      div_try;
    logic                div_ge;
    logic [ROW_W-1:0]    part_dvs;
    logic                part_ge;
    logic [UNIT_W-1:0]   unit_off;
    logic [UNIT_W-1:0]   first;
    logic [26:0]         limit;
    logic                too_long;

    // row size, stripe_count * stripe_unit
    assign row_prod = 26'(i_cfg.stripe_count) * 26'(i_cfg.stripe_unit);

    // one restoring step of offset / row
    assign div_try = {r_rem, r_quo[OFF_W-1]};
    assign div_ge  = div_try >= {1'b0, r_row};

    // one step of remainder / unit, quotient fits the part index
    assign part_dvs = ROW_W'({4'b0, i_cfg.stripe_unit} << r_cnt[1:0]);
    assign part_ge  = r_rem >= part_dvs;

    // too many chunks when len > first + (MAX_CHUNKS-1) * unit
    assign unit_off = r_rem[UNIT_W-1:0];
    assign first    = i_cfg.stripe_unit - unit_off;
    assign limit    = 27'(i_cfg.stripe_unit) * SPAN + 27'(first);
    assign too_long = 27'(r_len) > limit;

    assign o_busy          = (r_state != F_IDLE);
    assign o_desc.pbase    = r_acc;
    assign o_desc.part     = r_part;
    assign o_desc.unit_off = unit_off;
    assign o_desc.len      = r_len;
    assign o_desc.too_long = too_long;

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_row    = r_row;
        n_quo    = r_quo;
        n_rem    = r_rem;
        n_len    = r_len;
        n_part   = r_part;
        n_acc    = r_acc;
        n_mcand  = r_mcand;
        n_mplier = r_mplier;
        o_push   = 1'b0;
        unique case (r_state)
            F_IDLE: begin
                if (i_start && (i_write_length != '0)) begin
                    n_row   = row_prod[ROW_W-1:0];
                    n_quo   = i_write_offset;
                    n_rem   = '0;
                    n_len   = i_write_length;
                    n_cnt   = 6'(OFF_W - 1);
                    n_state = F_DIV;
                end
            end
            F_DIV: begin
                n_rem = div_ge ? ROW_W'(div_try - {1'b0, r_row}) : div_try[ROW_W-1:0];
                n_quo = {r_quo[OFF_W-2:0], div_ge};
                n_cnt = r_cnt - 6'd1;
                if (r_cnt == '0) begin
                    n_cnt   = 6'(PART_W - 1);
                    n_part  = '0;
                    n_state = F_PART;
                end
            end
            F_PART: begin
                if (part_ge) begin
                    n_rem = r_rem - part_dvs;
                end
                n_part = {r_part[PART_W-2:0], part_ge};
                n_cnt  = r_cnt - 6'd1;
                if (r_cnt == '0) begin
                    n_mcand  = r_quo;
                    n_mplier = i_cfg.stripe_unit;
                    n_acc    = '0;
                    n_cnt    = 6'(UNIT_W - 1);
                    n_state  = F_MUL;
                end
            end
            F_MUL: begin
                // shift-add row index * unit, modulo 2^40
                if (r_mplier[0]) begin
                    n_acc = r_acc + r_mcand;
                end
                n_mcand  = {r_mcand[OFF_W-2:0], 1'b0};
                n_mplier = {1'b0, r_mplier[UNIT_W-1:1]};
                n_cnt    = r_cnt - 6'd1;
                if (r_cnt == '0) begin
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!i_full) begin
                    o_push  = 1'b1;
                    n_state = F_IDLE;
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_row    <= n_row;
        r_quo    <= n_quo;
        r_rem    <= n_rem;
        r_len    <= n_len;
        r_part   <= n_part;
        r_acc    <= n_acc;
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
    end

endmodule

// File: rtl/core/sws_fifo.sv
// Two-entry descriptor queue between front and back.
module sws_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  sws_pkg::t_desc i_data,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output sws_pkg::t_desc o_data
);
    import sws_pkg::*;

    localparam int unsigned DEPTH = 2;
    localparam int unsigned PTR_W = $clog2(DEPTH);

    t_desc              r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wptr, n_wptr;
    logic [PTR_W-1:0]   r_rptr, n_rptr;
    logic [PTR_W:0]     r_count, n_count;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_count == (PTR_W+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // pointers and fill level
    always_comb begin
        n_wptr  = do_push ? PTR_W'(r_wptr + 1'b1) : r_wptr;
        n_rptr  = do_pop  ? PTR_W'(r_rptr + 1'b1) : r_rptr;
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

// File: rtl/core/sws_back.sv
// Back end: walks one descriptor at a time and issues a chunk word each cycle while it is active.
module sws_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  sws_pkg::t_cfg  i_cfg,
    input  logic           i_empty,
    input  sws_pkg::t_desc i_desc,
    output logic           o_pop,
    output logic           o_valid,
    output sws_pkg::t_chunk o_chunk
);
    import sws_pkg::*;

    // part modulo writer count, both narrow: four restoring steps
    function automatic logic [PART_W-1:0] mod_small(input logic [PART_W-1:0] a,
                                                    input logic [CNT_W-1:0] b);
        logic [7:0] rem;
        logic [7:0] dvs;
        rem = 8'(a);
        for (int i = PART_W - 1; i >= 0; i--) begin
            dvs = 8'(b) << i;
            if (rem >= dvs) begin
                rem = rem - dvs;
            end
        end
        return rem[PART_W-1:0];
    endfunction

    logic              r_act, n_act;
    logic              r_valid, n_valid;
    t_chunk            r_chunk, n_chunk;
    logic [OFF_W-1:0]  r_pbase, n_pbase;
    logic [PART_W-1:0] r_part, n_part;
    logic [UNIT_W-1:0] r_within, n_within;
    logic [LEN_W-1:0]  r_left, n_left;
    logic [LEN_W-1:0]  r_done, n_done;
    logic              r_tl, n_tl;

    logic [UNIT_W-1:0] avail;
    logic              is_last;
    logic [UNIT_W-1:0] clen;
    logic              wrap;

    // current chunk
    assign avail   = i_cfg.stripe_unit - r_within;
    assign is_last = r_left <= LEN_W'(avail);
    assign clen    = is_last ? r_left[UNIT_W-1:0] : avail;
    assign wrap    = (5'({1'b0, r_part}) + 5'd1) == i_cfg.stripe_count;

    assign o_valid = r_valid;
    assign o_chunk = r_chunk;

    always_comb begin
        n_act    = r_act;
        n_valid  = 1'b0;
        n_chunk  = r_chunk;
        n_pbase  = r_pbase;
        n_part   = r_part;
        n_within = r_within;
        n_left   = r_left;
        n_done   = r_done;
        n_tl     = r_tl;
        o_pop    = 1'b0;
        if (r_act) begin
            n_valid = 1'b1;
            if (r_tl) begin
                // rejected write: one flagged word, fields zero
                n_chunk          = '0;
                n_chunk.last     = 1'b1;
                n_chunk.too_long = 1'b1;
                n_act            = 1'b0;
            end else begin
                n_chunk.part_index    = r_part;
                n_chunk.part_offset   = r_pbase + OFF_W'(r_within);
                n_chunk.chunk_length  = clen;
                n_chunk.source_offset = r_done;
                n_chunk.writer_index  = mod_small(r_part, i_cfg.writer_count);
                n_chunk.last          = is_last;
                n_chunk.too_long      = 1'b0;
                n_done   = r_done + LEN_W'(clen);
                n_left   = r_left - LEN_W'(clen);
                n_within = '0;
                if (wrap) begin
                    n_part  = '0;
                    n_pbase = r_pbase + OFF_W'(i_cfg.stripe_unit);
                end else begin
                    n_part  = r_part + 1'b1;
                end
                if (is_last) begin
                    n_act = 1'b0;
                end
            end
        end else if (!i_empty) begin
            // load next descriptor
            o_pop    = 1'b1;
            n_act    = 1'b1;
            n_pbase  = i_desc.pbase;
            n_part   = i_desc.part;
            n_within = i_desc.unit_off;
            n_left   = i_desc.len;
            n_done   = '0;
            n_tl     = i_desc.too_long;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_act   <= n_act;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_chunk  <= n_chunk;
        r_pbase  <= n_pbase;
        r_part   <= n_part;
        r_within <= n_within;
        r_left   <= n_left;
        r_done   <= n_done;
        r_tl     <= n_tl;
    end

endmodule

// File: rtl/core/stripe_write_splitter_unit.sv
// Top level of the stripe write splitter: register port, front, queue and back.
//
//  channel  | signals                         | flow control
//  ---------+---------------------------------+-------------------------------
//  write in | start, i_write_offset/length    | taken when start & length != 0 & !busy
//  chunk out| o_valid, o_part_index .. too_long| one-cycle strobe, no stall
//  config   | psel penable pwrite paddr pwdata | APB, pready tied high
//
// The front handles each write in turn: offset / row (one quotient bit a cycle),
// then the part index, the shift-add row base, and the push into the queue.
// The back issues one chunk word per cycle after it loads each write from the queue.
// Reset clears control state and loads the register defaults.
// A two-entry queue lets the front start the next write while chunks still go out.
`include "stripe_write_splitter_unit_macros.svh"

module stripe_write_splitter_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [sws_pkg::OFF_W-1:0]   i_write_offset,
    input  logic [sws_pkg::LEN_W-1:0]   i_write_length,
    output logic                        o_valid,
    output logic [sws_pkg::PART_W-1:0]  o_part_index,
    output logic [sws_pkg::OFF_W-1:0]   o_part_offset,
    output logic [sws_pkg::UNIT_W-1:0]  o_chunk_length,
    output logic [sws_pkg::LEN_W-1:0]   o_source_offset,
    output logic [sws_pkg::PART_W-1:0]  o_writer_index,
    output logic                        o_last,
    output logic                        o_too_long,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [3:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import sws_pkg::*;

    logic [CNT_W-1:0]  r_scount;
    logic [UNIT_W-1:0] r_unit;
    logic [CNT_W-1:0]  r_wcount;
    logic              cfg_wr;
    t_reg_idx          reg_idx;
    logic [CNT_W-1:0]  sat_scount;
    logic [UNIT_W-1:0] sat_unit;
    logic [CNT_W-1:0]  sat_wcount;
    t_cfg              cfg;

    logic              push;
    logic              pop;
    logic              full;
    logic              empty;
    t_desc             desc_in;
    t_desc             desc_out;
    t_chunk            chunk;

    // register port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = t_reg_idx'(paddr[3:2]);

    // saturate written values into range
    always_comb begin
        sat_scount = pwdata[CNT_W-1:0];
        if (sat_scount == '0) begin
            sat_scount = 5'd1;
        end else if (sat_scount > SCNT_MAX) begin
            sat_scount = SCNT_MAX;
        end
        sat_unit = pwdata[UNIT_W-1:0];
        if (sat_unit == '0) begin
            sat_unit = 21'd1;
        end else if (sat_unit > UNIT_MAX) begin
            sat_unit = UNIT_MAX;
        end
        sat_wcount = pwdata[CNT_W-1:0];
        if (sat_wcount == '0) begin
            sat_wcount = 5'd1;
        end else if (sat_wcount > WCNT_MAX) begin
            sat_wcount = WCNT_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scount <= RST_STRIPE_COUNT;
            r_unit   <= RST_STRIPE_UNIT;
            r_wcount <= RST_WRITER_COUNT;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_STRIPE_COUNT: r_scount <= sat_scount;
                REG_STRIPE_UNIT:  r_unit   <= sat_unit;
                REG_WRITER_COUNT: r_wcount <= sat_wcount;
                default: begin
                end
            endcase
        end
    end

    // readback
    always_comb begin
        unique case (reg_idx)
            REG_STRIPE_COUNT: prdata = 32'(r_scount);
            REG_STRIPE_UNIT:  prdata = 32'(r_unit);
            REG_WRITER_COUNT: prdata = 32'(r_wcount);
            default:          prdata = '0;
        endcase
    end

    assign cfg.stripe_count = r_scount;
    assign cfg.stripe_unit  = r_unit;
    assign cfg.writer_count = r_wcount;

    sws_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_start        (start),
        .i_write_offset (i_write_offset),
        .i_write_length (i_write_length),
        .o_busy         (busy),
        .i_full         (full),
        .o_push         (push),
        .o_desc         (desc_in)
    );

    sws_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (desc_in),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_data  (desc_out)
    );

    sws_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_empty (empty),
        .i_desc  (desc_out),
        .o_pop   (pop),
        .o_valid (o_valid),
        .o_chunk (chunk)
    );

    assign o_part_index    = chunk.part_index;
    assign o_part_offset   = chunk.part_offset;
    assign o_chunk_length  = chunk.chunk_length;
    assign o_source_offset = chunk.source_offset;
    assign o_writer_index  = chunk.writer_index;
    assign o_last          = chunk.last;
    assign o_too_long      = chunk.too_long;

    // checks
    `SWS_ASSERT_IMP(a_tl_last, i_clk, i_rst_n, o_valid && o_too_long, o_last)
    `SWS_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n,
                    start && !busy && (i_write_length != '0), busy)
    `SWS_ASSERT_IMP(a_chunk_len, i_clk, i_rst_n, o_valid && !o_too_long,
                    (o_chunk_length != '0) && (o_chunk_length <= r_unit))
    `SWS_ASSERT_IMP(a_lane_range, i_clk, i_rst_n, o_valid && !o_too_long,
                    ({1'b0, o_writer_index} < r_wcount) && ({1'b0, o_part_index} < r_scount))

endmodule
